// File: design/pct_pkg.sv
// Shared types and constants for the preprocessor conditional tracker.
package pct_pkg;

  localparam int unsigned MAX_NEST_DEF    = 32;
  localparam int unsigned MAX_INCLUDE_DEF = 16;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned ERR_W   = 4;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned MARK_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_IF      = 3'd0,
    MODE_ELIF    = 3'd1,
    MODE_ELSE    = 3'd2,
    MODE_ENDIF   = 3'd3,
    MODE_OTHER   = 3'd4,
    MODE_INC_ENT = 3'd5,
    MODE_EOS     = 3'd6
  } mode_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE            = 4'd0,
    ERR_ELIF_NO_IF      = 4'd1,
    ERR_ELIF_AFTER_ELSE = 4'd2,
    ERR_ELSE_NO_IF      = 4'd3,
    ERR_ELSE_AFTER_ELSE = 4'd4,
    ERR_ENDIF_NO_IF     = 4'd5,
    ERR_TOO_DEEP        = 4'd6,
    ERR_UNTERM_INC      = 4'd7,
    ERR_UNTERM_END      = 4'd8,
    ERR_UNKNOWN_DIR     = 4'd9,
    ERR_INC_TOO_DEEP    = 4'd10
  } err_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_NONE  = 2'd0,
    MARK_TAKEN = 2'd1,
    MARK_ELSE  = 2'd2
  } mark_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cond_true;
    logic              extra_tokens;
    logic              unknown_directive;
  } in_t;

  typedef struct packed {
    logic               suppressed;
    logic [ERR_W-1:0]   error_code;
    logic               syntax_error;
    logic [DEPTH_W-1:0] depth;
  } out_t;

endpackage

// File: design/pct_ram.sv
// Single-port-write, single-read synchronous RAM with same-address forwarding.
module pct_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 2,
  parameter int unsigned AW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] byp_data_q;
  logic             byp_q;
  logic             byp_d;

  // read-first array: a write to the address being read is forwarded
  assign byp_d = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= byp_d;
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

// File: design/preproc_conditional_tracker_top.sv
// Top level of the preprocessor conditional tracker: control, state and output register.
//
// Usage
//   Input channel: one classified source line per transaction (in_data_i, in_valid_i,
//   in_stall_o). Output channel: one result per input transaction (out_data_o,
//   out_valid_o, out_stall_i). Results leave in input order.
//   Latency: the result is registered at the accepting edge and is offered on
//   out_valid_o in the next cycle.
//   Throughput: one line per cycle while in_stall_o is low. Per-level marks and
//   include entry depths live in two synchronous RAMs; each is read ahead at the
//   address the next line will need (the next nesting depth, the next top of include
//   stack), so the registered read is hidden. A write to the entry being read ahead is
//   forwarded inside the RAM.
//   Stall: the output register parts the channels; a new line is taken whenever
//   the output register is empty or is being drained. in_stall_o is raised only
//   while a result is held and out_stall_i is high.
//   Reset: depth, skip level and include count clear to zero; the output register
//   empties. RAM contents are undefined until written and need no clearing pass,
//   as only written entries are ever read.
module preproc_conditional_tracker_top #(
  parameter int unsigned MAX_NEST    = pct_pkg::MAX_NEST_DEF,
  parameter int unsigned MAX_INCLUDE = pct_pkg::MAX_INCLUDE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pct_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pct_pkg::out_t out_data_o
);

  localparam int unsigned NW  = $clog2(MAX_NEST);
  localparam int unsigned CW  = $clog2(MAX_INCLUDE + 1);
  localparam int unsigned IAW = (MAX_INCLUDE > 1) ? $clog2(MAX_INCLUDE) : 1;

  // architectural state
  logic [NW-1:0] nest_q, nest_d;
  logic [NW-1:0] skip_q, skip_d;
  logic [CW-1:0] cnt_q,  cnt_d;

  // output register
  logic          out_valid_q;
  pct_pkg::out_t out_q;
  pct_pkg::out_t res;

  logic accept;

  // RAM ports
  logic                     mark_we;
  logic [NW-1:0]            mark_waddr;
  logic [pct_pkg::MARK_W-1:0] mark_wdata;
  logic [pct_pkg::MARK_W-1:0] mark_rd;
  logic                     inc_we;
  logic [IAW-1:0]           inc_raddr;
  logic [CW-1:0]            cnt_dm1;
  logic [NW-1:0]            inc_rd;

  // step helpers
  logic [NW-1:0]            base;
  logic                     src_zero;
  logic                     push_ok;
  logic [NW-1:0]            nest_inc;
  logic [NW-1:0]            nest_dec;
  logic                     active;
  pct_pkg::err_e            err;
  logic                     syn;
  logic [31:0]              depth_wide;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign base     = (cnt_q == '0) ? '0 : inc_rd;
  assign src_zero = (nest_q <= base);
  assign push_ok  = (({1'b0, nest_q} + (NW+1)'(1)) < (NW+1)'(MAX_NEST));
  assign nest_inc = nest_q + NW'(1);
  assign nest_dec = (nest_q != '0) ? (nest_q - NW'(1)) : nest_q;

  // one classified line per cycle while the input is not stalled
  always_comb begin
    nest_d     = nest_q;
    skip_d     = skip_q;
    cnt_d      = cnt_q;
    err        = pct_pkg::ERR_NONE;
    syn        = 1'b0;
    active     = 1'b1;
    mark_we    = 1'b0;
    mark_waddr = nest_q;
    mark_wdata = pct_pkg::MARK_NONE;
    inc_we     = 1'b0;

    if (accept) begin
      // skipped region: only nesting is followed, except elif/else at skip level and EOS
      if ((skip_q != '0) && (in_data_i.mode <= pct_pkg::MODE_INC_ENT)) begin
        active = 1'b0;
        case (in_data_i.mode)
          pct_pkg::MODE_IF: begin
            if (push_ok) nest_d = nest_inc;
            else         err    = pct_pkg::ERR_TOO_DEEP;
          end
          pct_pkg::MODE_ENDIF: begin
            nest_d = nest_dec;
            if (nest_dec < skip_q) skip_d = '0;
          end
          pct_pkg::MODE_ELIF, pct_pkg::MODE_ELSE: begin
            if (nest_q <= skip_q) active = 1'b1;
          end
          default: begin
          end
        endcase
      end

      if (active) begin
        case (in_data_i.mode)
          pct_pkg::MODE_IF: begin
            if (!push_ok) begin
              err = pct_pkg::ERR_TOO_DEEP;
            end else begin
              nest_d     = nest_inc;
              mark_we    = 1'b1;
              mark_waddr = nest_inc;
              mark_wdata = in_data_i.cond_true ? pct_pkg::MARK_TAKEN : pct_pkg::MARK_NONE;
              if (!in_data_i.cond_true) skip_d = nest_inc;
            end
          end
          pct_pkg::MODE_ELIF: begin
            if (src_zero) begin
              err = pct_pkg::ERR_ELIF_NO_IF;
            end else begin
              if (mark_rd == pct_pkg::MARK_ELSE) err = pct_pkg::ERR_ELIF_AFTER_ELSE;
              if (!in_data_i.cond_true) begin
                skip_d = nest_q;
              end else if (mark_rd != pct_pkg::MARK_NONE) begin
                skip_d = nest_q;
              end else begin
                skip_d     = '0;
                mark_we    = 1'b1;
                mark_wdata = pct_pkg::MARK_TAKEN;
              end
            end
          end
          pct_pkg::MODE_ELSE: begin
            if (src_zero) begin
              err = pct_pkg::ERR_ELSE_NO_IF;
            end else begin
              if (mark_rd == pct_pkg::MARK_ELSE) err = pct_pkg::ERR_ELSE_AFTER_ELSE;
              syn        = in_data_i.extra_tokens;
              skip_d     = (mark_rd != pct_pkg::MARK_NONE) ? nest_q : '0;
              mark_we    = 1'b1;
              mark_wdata = pct_pkg::MARK_ELSE;
            end
          end
          pct_pkg::MODE_ENDIF: begin
            if (src_zero) begin
              err = pct_pkg::ERR_ENDIF_NO_IF;
            end else begin
              nest_d = nest_dec;
              syn    = in_data_i.extra_tokens;
            end
          end
          pct_pkg::MODE_INC_ENT: begin
            if (cnt_q >= CW'(MAX_INCLUDE)) begin
              err = pct_pkg::ERR_INC_TOO_DEEP;
            end else begin
              inc_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end
          end
          pct_pkg::MODE_EOS: begin
            if (cnt_q != '0) begin
              if (nest_q != base) err    = pct_pkg::ERR_UNTERM_INC;
              if (nest_q > base)  nest_d = base;
              if (skip_q > base)  skip_d = '0;
              cnt_d = cnt_q - CW'(1);
            end else if (nest_q != '0) begin
              err = pct_pkg::ERR_UNTERM_END;
            end
          end
          pct_pkg::MODE_OTHER: begin
            if (in_data_i.unknown_directive) err = pct_pkg::ERR_UNKNOWN_DIR;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign depth_wide = 32'(nest_d);

  always_comb begin
    res.suppressed   = (skip_d != '0);
    res.error_code   = err;
    res.syntax_error = syn;
    res.depth        = depth_wide[pct_pkg::DEPTH_W-1:0];
  end

  // read-ahead addresses follow the next state
  assign cnt_dm1   = cnt_d - CW'(1);
  assign inc_raddr = IAW'(cnt_dm1);

  pct_ram #(
    .DEPTH (MAX_NEST),
    .WIDTH (pct_pkg::MARK_W),
    .AW    (NW)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (nest_d),
    .rdata_o (mark_rd)
  );

  pct_ram #(
    .DEPTH (MAX_INCLUDE),
    .WIDTH (NW),
    .AW    (IAW)
  ) u_inc_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (inc_we),
    .waddr_i (IAW'(cnt_q)),
    .wdata_i (nest_q),
    .raddr_i (inc_raddr),
    .rdata_o (inc_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q      <= '0;
      skip_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      nest_q <= nest_d;
      skip_q <= skip_d;
      cnt_q  <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // skipping never starts above the current depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != '0) |-> (skip_q <= nest_q))
    else $error("skip level above nesting depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, nest_q}) < (NW+1)'(MAX_NEST)) && (cnt_q <= CW'(MAX_INCLUDE)))
    else $error("nesting or include stack out of bounds");

  // an accepted transaction is always offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction lost");

  // state moves only on an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(nest_q) && $stable(skip_q) && $stable(cnt_q)))
    else $error("state changed without a transaction");

endmodule
